// ----- rtl/bms_pkg.sv -----
// Shared types and constants of the buzzer melody sequencer.
`default_nettype none
package bms_pkg;

    // command codes carried on s_tuser
    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_START = 2'd1;
    localparam logic [1:0] FUNC_TICK  = 2'd2;
    localparam logic [1:0] FUNC_STOP  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_TEMPO  = 2'd0;
    localparam logic [1:0] CFG_COUNT  = 2'd1;
    localparam logic [1:0] CFG_REPEAT = 2'd2;
    localparam logic [1:0] CFG_SOUND  = 2'd3;

    // tone timer clock selects
    localparam logic [1:0] CLK_OFF   = 2'd0;
    localparam logic [1:0] CLK_DIV1  = 2'd1;
    localparam logic [1:0] CLK_DIV64 = 2'd2;

    // shared divider: dividend and quotient width, divisor width
    localparam int DIV_W = 34;
    localparam int DVS_W = 16;

    localparam logic [31:0] TOGGLES_INDEF = 32'hFFFF_FFFF;
    localparam logic [31:0] TOGGLES_MAX   = 32'hFFFF_FFFE;
    localparam logic [DIV_W-1:0] WHOLE_NUM = DIV_W'(240000);
    localparam logic [DVS_W-1:0] MS_PER_S  = DVS_W'(1000);

    // which setup step a running division belongs to
    typedef enum logic [1:0] {
        STEP_PERIOD,
        STEP_WHOLE,
        STEP_DUR,
        STEP_TOGGLES
    } div_step_t;

endpackage
`default_nettype wire

// ----- rtl/buzzer_melody_sequencer_unit.sv -----
// Buzzer melody sequencer: note table, note setup sequencer and tick handling.
//
// Usage: commands enter on the s_ channel (s_tuser selects write entry, start,
// tick or stop; s_tdata carries the entry index, frequency and divider).
// Every accepted command yields exactly one status word on the m_ channel;
// m_tlast marks the tick on which the melody ends. Registers are written
// through cfg_we / cfg_index / cfg_wdata; the user must write them only while
// the block is idle, which the block does not enforce. Writes, stops, idle
// ticks and ticks inside a note go via ST_OUT to the output register. A tick
// leaving a note first wraps the position, subtracting the melody length (at
// most once normally, up to 256 times if the count was lowered mid-melody);
// a melody end stops there. A start or a note change runs the note setup: one
// table read, up to four divisions on the shared one-bit-per-cycle divider and
// one multiply. One command is in work at a time; s_tready stays low until its
// status word is registered, and the output register holds it while the
// receiver stalls; the next command is taken once that word leaves or as it
// leaves. Reset (aresetn low, synchronous) clears the control state and sets
// tempo 120, one note, endless repeat, sound on; the note table is not cleared.
`default_nettype none
module buzzer_melody_sequencer_unit #(
    parameter int NOTE_DEPTH = 256,
    parameter int CLOCK_HZ   = 32000000
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // config write port
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata,
    // command channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // s_tdata: entry_index[7:0], note_frequency[22:8], note_divider[30:23], pad
    input  wire logic [31:0] s_tdata,
    // s_tuser: func
    input  wire logic [1:0]  s_tuser,
    // status channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // m_tdata: buzzer_level[0], clock_select[2:1], timer_period[18:3],
    //          playing[19], note_pos[27:20], loops_left[43:28], pad
    output logic [47:0]      m_tdata,
    // finished
    output logic             m_tlast
);
    import bms_pkg::*;

    localparam int PW    = (NOTE_DEPTH > 2) ? $clog2(NOTE_DEPTH) : 1;
    localparam int LEN_W = ($clog2(NOTE_DEPTH + 1) > 9) ? $clog2(NOTE_DEPTH + 1) : 9;
    localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(NOTE_DEPTH);
    localparam logic [DIV_W-1:0] CLK_DVD   = DIV_W'(CLOCK_HZ);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_ENT  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_POST = 3'd4;
    localparam logic [2:0] ST_MUL  = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;
    localparam logic [2:0] ST_WRAP = 3'd7;

    logic [2:0]  st_reg;

    // config registers
    logic [15:0] tempo_reg;
    logic [8:0]  count_reg;
    logic [15:0] repeat_reg;
    logic        sound_reg;

    // player state
    logic [PW-1:0] pos_reg;
    logic [15:0]   loops_reg;
    logic          forever_reg;
    logic [31:0]   total_reg;
    logic [31:0]   left_reg;
    logic          pin_reg;
    logic [1:0]    clk_sel_reg;
    logic [15:0]   period_reg;
    logic          active_reg;
    logic          fin_reg;

    // note setup working registers
    logic [14:0]      freq_reg;
    logic [7:0]       mag_reg;
    logic             dotted_reg;
    logic [16:0]      dur_reg;
    logic [LEN_W-1:0] wrap_reg;

    // shared divider
    div_step_t        step_reg;
    logic [DIV_W-1:0] dq_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [5:0]       div_cnt_reg;

    // note table
    logic [22:0] note_mem [NOTE_DEPTH];
    logic [22:0] rd_data_reg;

    // output register
    logic        m_valid_reg;
    logic [47:0] m_data_reg;
    logic        m_last_reg;

    logic        accept;
    logic [14:0] in_freq;
    logic [7:0]  in_div;
    logic [7:0]  in_idx;

    assign s_tready = (st_reg == ST_IDLE) && (!m_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign in_idx   = s_tdata[7:0];
    assign in_freq  = s_tdata[22:8];
    assign in_div   = s_tdata[30:23];
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    // table write on entry command, registered read at the play position
    always_ff @(posedge aclk) begin
        if (accept && (s_tuser == FUNC_WRITE) && ({24'd0, in_idx} < 32'(NOTE_DEPTH))) begin
            note_mem[PW'(in_idx)] <= {in_div, in_freq};
        end
        rd_data_reg <= note_mem[pos_reg];
    end

    // divider step
    logic [DVS_W:0]   div_trial;
    logic             div_ge;
    assign div_trial = {rem_reg, dq_reg[DIV_W-1]};
    assign div_ge    = div_trial >= {1'b0, dvs_reg};

    // melody length and loop count after a note change
    logic [LEN_W-1:0] mel_len;
    logic [LEN_W-1:0] pos_inc;
    logic [15:0]      loops_dec;
    always_comb begin
        mel_len = LEN_W'(count_reg);
        if (count_reg == 9'd0) begin
            mel_len = LEN_W'(1);
        end
        if (mel_len > DEPTH_LEN) begin
            mel_len = DEPTH_LEN;
        end
        pos_inc   = LEN_W'(pos_reg) + LEN_W'(1);
        loops_dec = loops_reg;
        if ((wrap_reg == '0) && !forever_reg && (loops_reg != 16'd0)) begin
            loops_dec = loops_reg - 16'd1;
        end
    end

    // loud unless in the last tenth of a finite note
    logic [35:0] left_x10;
    logic        loud;
    assign left_x10 = {1'b0, left_reg, 3'b0} + {3'b0, left_reg, 1'b0};
    assign loud     = (left_reg == TOGGLES_INDEF) || (left_x10 > {4'd0, total_reg});

    // timer setting from CLOCK_HZ / freq
    logic [DIV_W-1:0] half_q;
    logic [DIV_W-1:0] p1;
    logic [DIV_W-1:0] q64;
    logic [DIV_W-1:0] p64;
    logic [1:0]       clk_calc;
    logic [15:0]      period_calc;
    always_comb begin
        half_q = dq_reg >> 1;
        p1     = (half_q == '0) ? '0 : half_q - DIV_W'(1);
        q64    = half_q >> 6;
        p64    = (q64 == '0) ? '0 : q64 - DIV_W'(1);
        if (p1 > DIV_W'(16'hFFFF)) begin
            clk_calc    = CLK_DIV64;
            period_calc = (p64 > DIV_W'(16'hFFFF)) ? 16'hFFFF : p64[15:0];
        end else begin
            clk_calc    = CLK_DIV1;
            period_calc = p1[15:0];
        end
    end

    logic [16:0] dur_calc;
    assign dur_calc = {1'b0, dq_reg[15:0]} + (dotted_reg ? {2'b0, dq_reg[15:1]} : 17'd0);

    logic [31:0] prod;
    assign prod = 32'(freq_reg) * 32'(dur_reg);

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= ST_IDLE;
            tempo_reg   <= 16'd120;
            count_reg   <= 9'd1;
            repeat_reg  <= 16'd0;
            sound_reg   <= 1'b1;
            pos_reg     <= '0;
            loops_reg   <= 16'd0;
            forever_reg <= 1'b0;
            total_reg   <= TOGGLES_INDEF;
            left_reg    <= TOGGLES_INDEF;
            pin_reg     <= 1'b0;
            clk_sel_reg <= CLK_OFF;
            period_reg  <= 16'd0;
            active_reg  <= 1'b0;
            fin_reg     <= 1'b0;
            div_cnt_reg <= 6'd0;
            m_valid_reg <= 1'b0;
            m_last_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_TEMPO:  tempo_reg  <= cfg_wdata;
                    CFG_COUNT:  count_reg  <= cfg_wdata[8:0];
                    CFG_REPEAT: repeat_reg <= cfg_wdata;
                    CFG_SOUND:  sound_reg  <= cfg_wdata[0];
                    default:    ;
                endcase
            end
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (st_reg)
                ST_IDLE: begin
                    if (accept) begin
                        fin_reg <= 1'b0;
                        st_reg  <= ST_OUT;
                        unique case (s_tuser)
                            FUNC_START: begin
                                if (count_reg != 9'd0) begin
                                    pos_reg     <= '0;
                                    forever_reg <= (repeat_reg == 16'd0);
                                    loops_reg   <= repeat_reg;
                                    active_reg  <= 1'b1;
                                    st_reg      <= ST_RD;
                                end
                            end
                            FUNC_TICK: begin
                                if (active_reg) begin
                                    if (left_reg != 32'd0) begin
                                        if (sound_reg && loud) begin
                                            pin_reg <= !pin_reg;
                                        end
                                        if (left_reg != TOGGLES_INDEF) begin
                                            left_reg <= left_reg - 32'd1;
                                        end
                                    end else begin
                                        wrap_reg <= pos_inc;
                                        st_reg   <= ST_WRAP;
                                    end
                                end
                            end
                            FUNC_STOP: begin
                                left_reg    <= TOGGLES_INDEF;
                                clk_sel_reg <= CLK_OFF;
                                active_reg  <= 1'b0;
                            end
                            default: ;
                        endcase
                    end
                end
                // next position modulo the melody length, then loop count
                ST_WRAP: begin
                    if (wrap_reg >= mel_len) begin
                        wrap_reg <= wrap_reg - mel_len;
                    end else begin
                        pos_reg   <= PW'(wrap_reg);
                        loops_reg <= loops_dec;
                        if (forever_reg || (loops_dec != 16'd0)) begin
                            st_reg <= ST_RD;
                        end else begin
                            left_reg    <= TOGGLES_INDEF;
                            clk_sel_reg <= CLK_OFF;
                            active_reg  <= 1'b0;
                            fin_reg     <= 1'b1;
                            st_reg      <= ST_OUT;
                        end
                    end
                end
                ST_RD: begin
                    st_reg <= ST_ENT;
                end
                ST_ENT: begin
                    freq_reg   <= rd_data_reg[14:0];
                    dotted_reg <= rd_data_reg[22];
                    mag_reg    <= rd_data_reg[22] ? 8'(-rd_data_reg[22:15]) : rd_data_reg[22:15];
                    if (rd_data_reg[14:0] == 15'd0) begin
                        clk_sel_reg <= CLK_OFF;
                        period_reg  <= 16'd0;
                        total_reg   <= 32'd0;
                        left_reg    <= 32'd0;
                        st_reg      <= ST_OUT;
                    end else begin
                        dq_reg      <= CLK_DVD;
                        dvs_reg     <= DVS_W'(rd_data_reg[14:0]);
                        rem_reg     <= '0;
                        div_cnt_reg <= 6'd0;
                        step_reg    <= STEP_PERIOD;
                        st_reg      <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    rem_reg     <= div_ge ? DVS_W'(div_trial - {1'b0, dvs_reg})
                                          : DVS_W'(div_trial);
                    dq_reg      <= {dq_reg[DIV_W-2:0], div_ge};
                    div_cnt_reg <= div_cnt_reg + 6'd1;
                    if (div_cnt_reg == 6'(DIV_W - 1)) begin
                        st_reg <= ST_POST;
                    end
                end
                ST_POST: begin
                    rem_reg     <= '0;
                    div_cnt_reg <= 6'd0;
                    unique case (step_reg)
                        STEP_PERIOD: begin
                            clk_sel_reg <= clk_calc;
                            period_reg  <= period_calc;
                            if (mag_reg == 8'd0) begin
                                total_reg <= TOGGLES_INDEF;
                                left_reg  <= TOGGLES_INDEF;
                                st_reg    <= ST_OUT;
                            end else if (tempo_reg == 16'd0) begin
                                // zero tempo: whole note saturates
                                dq_reg   <= DIV_W'(16'hFFFF);
                                dvs_reg  <= DVS_W'(mag_reg);
                                step_reg <= STEP_DUR;
                                st_reg   <= ST_DIV;
                            end else begin
                                dq_reg   <= WHOLE_NUM;
                                dvs_reg  <= tempo_reg;
                                step_reg <= STEP_WHOLE;
                                st_reg   <= ST_DIV;
                            end
                        end
                        STEP_WHOLE: begin
                            dq_reg   <= DIV_W'(dq_reg[15:0]);
                            dvs_reg  <= DVS_W'(mag_reg);
                            step_reg <= STEP_DUR;
                            st_reg   <= ST_DIV;
                        end
                        STEP_DUR: begin
                            dur_reg <= dur_calc;
                            st_reg  <= ST_MUL;
                        end
                        STEP_TOGGLES: begin
                            if (dq_reg > DIV_W'(TOGGLES_MAX)) begin
                                total_reg <= TOGGLES_MAX;
                                left_reg  <= TOGGLES_MAX;
                            end else begin
                                total_reg <= dq_reg[31:0];
                                left_reg  <= dq_reg[31:0];
                            end
                            st_reg <= ST_OUT;
                        end
                        default: st_reg <= ST_OUT;
                    endcase
                end
                ST_MUL: begin
                    dq_reg   <= {1'b0, prod, 1'b0};
                    dvs_reg  <= MS_PER_S;
                    step_reg <= STEP_TOGGLES;
                    st_reg   <= ST_DIV;
                end
                ST_OUT: begin
                    m_valid_reg <= 1'b1;
                    m_last_reg  <= fin_reg;
                    m_data_reg  <= {4'd0, forever_reg ? 16'd0 : loops_reg, 8'(pos_reg),
                                    active_reg, period_reg, clk_sel_reg, pin_reg};
                    st_reg      <= ST_IDLE;
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end

    // checks on sequencer consistency
    a_idle_clock_off: assert property (@(posedge aclk) disable iff (!aresetn)
        !active_reg |-> (clk_sel_reg == CLK_OFF))
        else $error("clock running while not playing");
    a_div_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_DIV) |-> (div_cnt_reg < 6'(DIV_W)))
        else $error("divider ran past its width");
    a_fin_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_last_reg) |-> !m_data_reg[19])
        else $error("finished word reports playing");
    a_busy_no_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg != ST_IDLE) |-> !s_tready)
        else $error("ready during note setup");
    a_out_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_OUT) |=> m_valid_reg)
        else $error("status word lost");

endmodule
`default_nettype wire
